/* rtl/bcdd_pkg.sv */
// Shared types and constants for the derated charge-delta block.
// Holds field widths, breakpoint axes, the capacity table and the queue word.
// No dependencies.
package bcdd_pkg;

  // port field widths
  localparam int CUR_W     = 20;
  localparam int TEMP_W    = 8;
  localparam int CAP_W     = 20;
  localparam int INT_W     = 16;
  localparam int CFG_W     = 20;
  localparam int DELTA_W   = 32;
  localparam int PCT_W     = 23;

  // register map
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 1'b1;
  localparam logic [CAP_W-1:0]     CAP_RESET    = 20'd1000;
  localparam logic [INT_W-1:0]     INT_RESET    = 16'd1000;

  // interpolation grid
  localparam int TEMP_POINTS = 6;
  localparam int RATE_POINTS = 5;
  localparam int TIDX_W      = $clog2(TEMP_POINTS);
  localparam int RIDX_W      = $clog2(RATE_POINTS);
  localparam int TBL_W       = 7;

  // rate is Q16, clamped at 4.0 = 2^18
  localparam int RATE_FRAC = 16;
  localparam int RATE_W    = 19;
  localparam int RQ_BITS   = 18;
  localparam int RDROP     = RQ_BITS - RATE_FRAC;
  localparam int RSPAN_W   = RATE_FRAC + 1;
  localparam int KSH_W     = $clog2(RATE_FRAC + 1);
  localparam int TSPAN_W   = 5;

  localparam int WPROD_W = RSPAN_W + TSPAN_W;
  localparam int CPROD_W = WPROD_W + TBL_W;
  localparam int CSUM_W  = CPROD_W + 2;
  localparam int SUM_W   = 28;
  localparam int AQ_BITS = PCT_W;

  // charge step: mag * interval * 2^27 / (1125 * avail)
  localparam int PROD_W    = CUR_W + INT_W;
  localparam int DEN_W     = 34;
  localparam int CHG_SHIFT = 27;
  localparam int CQ_BITS   = DELTA_W;
  localparam int CDROP     = CQ_BITS - CHG_SHIFT;
  localparam logic [10:0] CHG_DEN = 11'd1125;

  localparam logic [DELTA_W-1:0] DELTA_MAX     = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic [DELTA_W-1:0] DELTA_MIN_MAG = {1'b1, {(DELTA_W-1){1'b0}}};

  localparam logic [PCT_W-1:0] PCT_LOW  = 23'd4259840;  // 65 percent
  localparam logic [PCT_W-1:0] PCT_HIGH = 23'd6553600;  // 100 percent

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic signed [TEMP_W-1:0] TEMP_AXIS [TEMP_POINTS] =
    '{-8'sd20, -8'sd10, 8'sd0, 8'sd10, 8'sd25, 8'sd55};

  localparam logic [RATE_W-1:0] RATE_AXIS [RATE_POINTS] =
    '{19'd32768, 19'd65536, 19'd131072, 19'd196608, 19'd262144};

  localparam logic [TBL_W-1:0] AVAIL_TABLE [TEMP_POINTS][RATE_POINTS] = '{
    '{7'd65,  7'd68,  7'd72,  7'd78,  7'd75},
    '{7'd85,  7'd85,  7'd81,  7'd80,  7'd75},
    '{7'd90,  7'd90,  7'd83,  7'd83,  7'd83},
    '{7'd98,  7'd95,  7'd90,  7'd88,  7'd88},
    '{7'd100, 7'd98,  7'd95,  7'd90,  7'd90},
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd98}
  };

  typedef struct packed {
    logic             neg;
    logic [CUR_W-1:0] mag;
    logic [PCT_W-1:0] avail;
  } bcdd_word_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

/* rtl/battery_charge_delta_derated.sv */
// Coulomb-counter step with temperature and rate derated capacity.
// Top level: configuration registers, front end, queue and back end.
// Uses bcdd_pkg, bcdd_front, bcdd_queue, bcdd_back.
//
// Usage:
//   A sample (current_ma, temperature_c) is taken at a clock edge where start
//   is high and busy is low. One result per sample appears on charge_delta and
//   available_pct for exactly one cycle, flagged by done, after the front end,
//   queue and back end have passed it through; results leave in sample order.
//   Throughput is one sample per clock. The pipeline length is set by the three
//   bit-per-stage dividers (rate: 18 stages, capacity percent: 23 stages,
//   charge step: 32 stages) plus the interpolation multiply stages.
//   The receiver cannot hold results off; the back end drains the queue
//   every cycle, so busy only rises if the queue ever fills.
//   Registers: wr_en with wr_index selects capacity_mah or
//   sample_interval_ms, written from wr_data at that edge; change them only
//   with no samples in flight.
//   Reset (rst, synchronous) empties the pipeline and queue and restores
//   capacity 1000 mAh and interval 1000 ms. There is no clearing pass.
module battery_charge_delta_derated (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bcdd_pkg::CUR_W-1:0]   current_ma,
  input  logic signed [bcdd_pkg::TEMP_W-1:0]  temperature_c,
  input  logic                                wr_en,
  input  logic [bcdd_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [bcdd_pkg::CFG_W-1:0]          wr_data,
  output logic                                done,
  output logic signed [bcdd_pkg::DELTA_W-1:0] charge_delta,
  output logic [bcdd_pkg::PCT_W-1:0]          available_pct
);
  import bcdd_pkg::*;

  logic [CAP_W-1:0] capacity_mah;
  logic [INT_W-1:0] sample_interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_mah       <= CAP_RESET;
      sample_interval_ms <= INT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CAPACITY: capacity_mah       <= wr_data[CAP_W-1:0];
        REG_INTERVAL: sample_interval_ms <= wr_data[INT_W-1:0];
      endcase
    end
  end

  logic       accept;
  logic       f_valid;
  bcdd_word_t f_word;
  q_status_t  q_status;
  bcdd_word_t q_head;
  logic       q_pop;

  assign busy   = q_status.full;
  assign accept = start && !busy;

  bcdd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .current_ma    (current_ma),
    .temperature_c (temperature_c),
    .capacity_mah  (capacity_mah),
    .out_valid     (f_valid),
    .out_word      (f_word)
  );

  bcdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_word (f_word),
    .pop       (q_pop),
    .status    (q_status),
    .head      (q_head)
  );

  bcdd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_status           (q_status),
    .in_word            (q_head),
    .sample_interval_ms (sample_interval_ms),
    .pop                (q_pop),
    .done               (done),
    .charge_delta       (charge_delta),
    .available_pct      (available_pct)
  );

endmodule

/* rtl/bcdd_front.sv */
// Front end: takes a sample, forms the clamped discharge rate and interpolates
// the available capacity. Pipelined, one sample per clock. Uses bcdd_pkg.
module bcdd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [bcdd_pkg::CUR_W-1:0]  current_ma,
  input  logic signed [bcdd_pkg::TEMP_W-1:0] temperature_c,
  input  logic [bcdd_pkg::CAP_W-1:0]         capacity_mah,
  output logic                               out_valid,
  output bcdd_pkg::bcdd_word_t               out_word
);
  import bcdd_pkg::*;

  // ---- input capture ----
  logic [CUR_W-1:0]         in_mag;
  logic signed [TEMP_W-1:0] in_temp;
  logic                     in_over;

  always_comb begin
    in_mag = current_ma[CUR_W-1] ? (~current_ma + 1'b1) : current_ma;
    if (temperature_c < TEMP_AXIS[0]) begin
      in_temp = TEMP_AXIS[0];
    end else if (temperature_c > TEMP_AXIS[TEMP_POINTS-1]) begin
      in_temp = TEMP_AXIS[TEMP_POINTS-1];
    end else begin
      in_temp = temperature_c;
    end
    // quotient would reach 4.0 or more (also catches zero capacity)
    in_over = (in_mag >> RDROP) >= capacity_mah;
  end

  // ---- rate divider, one quotient bit per stage ----
  logic                     r_v    [RQ_BITS+1];
  logic [CUR_W-1:0]         r_mag  [RQ_BITS+1];
  logic                     r_neg  [RQ_BITS+1];
  logic signed [TEMP_W-1:0] r_temp [RQ_BITS+1];
  logic                     r_over [RQ_BITS+1];
  logic [RQ_BITS-1:0]       r_q    [RQ_BITS+1];
  logic [CAP_W-1:0]         r_rem  [RQ_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v[0] <= 1'b0;
    end else begin
      r_v[0] <= in_valid;
    end
    r_mag[0]  <= in_mag;
    r_neg[0]  <= current_ma[CUR_W-1];
    r_temp[0] <= in_temp;
    r_over[0] <= in_over;
    r_q[0]    <= '0;
    r_rem[0]  <= in_mag >> RDROP;
  end

  for (genvar s = 1; s <= RQ_BITS; s++) begin : g_rdiv
    logic [RQ_BITS-1:0] low;
    logic [CAP_W:0]     t;
    logic               ge;

    assign low = RQ_BITS'({r_mag[s-1], {RATE_FRAC{1'b0}}});
    assign t   = {r_rem[s-1], low[RQ_BITS-s]};
    assign ge  = t >= {1'b0, capacity_mah};

    always_ff @(posedge clk) begin
      if (rst) begin
        r_v[s] <= 1'b0;
      end else begin
        r_v[s] <= r_v[s-1];
      end
      r_mag[s]  <= r_mag[s-1];
      r_neg[s]  <= r_neg[s-1];
      r_temp[s] <= r_temp[s-1];
      r_over[s] <= r_over[s-1];
      r_q[s]    <= {r_q[s-1][RQ_BITS-2:0], ge};
    end

    if (s < RQ_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        r_rem[s] <= ge ? CAP_W'(t - {1'b0, capacity_mah}) : t[CAP_W-1:0];
      end
    end
  end

  // ---- clamp and bracket ----
  logic [RATE_W-1:0]  rate;
  logic [RIDX_W-1:0]  rlo, rhi;
  logic [TIDX_W-1:0]  tlo, thi;
  logic               rcol, tcol;
  logic [RSPAN_W-1:0] dr, fr;
  logic [TSPAN_W-1:0] dt, ft;
  logic [KSH_W-1:0]   ksh;

  always_comb begin
    if (r_over[RQ_BITS]) begin
      rate = RATE_AXIS[RATE_POINTS-1];
    end else if ({1'b0, r_q[RQ_BITS]} < RATE_AXIS[0]) begin
      rate = RATE_AXIS[0];
    end else begin
      rate = {1'b0, r_q[RQ_BITS]};
    end

    rlo = '0;
    for (int i = 1; i < RATE_POINTS; i++) begin
      if (rate >= RATE_AXIS[i]) rlo = RIDX_W'(i);
    end
    rcol = rate == RATE_AXIS[rlo];
    rhi  = rcol ? rlo : rlo + 1'b1;
    dr   = rcol ? RSPAN_W'(1) : RSPAN_W'(RATE_AXIS[rhi] - RATE_AXIS[rlo]);
    fr   = RSPAN_W'(rate - RATE_AXIS[rlo]);

    // spans are powers of two: 65536 / dr as a shift
    ksh = '0;
    for (int b = 0; b < RSPAN_W; b++) begin
      if (dr[b]) ksh = KSH_W'(RATE_FRAC - b);
    end

    tlo = '0;
    for (int i = 1; i < TEMP_POINTS; i++) begin
      if (r_temp[RQ_BITS] >= TEMP_AXIS[i]) tlo = TIDX_W'(i);
    end
    tcol = r_temp[RQ_BITS] == TEMP_AXIS[tlo];
    thi  = tcol ? tlo : tlo + 1'b1;
    dt   = tcol ? TSPAN_W'(1) : TSPAN_W'(TEMP_AXIS[thi] - TEMP_AXIS[tlo]);
    ft   = TSPAN_W'(r_temp[RQ_BITS] - TEMP_AXIS[tlo]);
  end

  logic               b_v;
  logic [CUR_W-1:0]   b_mag;
  logic               b_neg;
  logic [TBL_W-1:0]   b_vll, b_vlh, b_vhl, b_vhh;
  logic [RSPAN_W-1:0] b_wr0, b_wr1;
  logic [TSPAN_W-1:0] b_wt0, b_wt1, b_dt;
  logic [KSH_W-1:0]   b_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= r_v[RQ_BITS];
    end
    b_mag <= r_mag[RQ_BITS];
    b_neg <= r_neg[RQ_BITS];
    b_vll <= AVAIL_TABLE[tlo][rlo];
    b_vlh <= AVAIL_TABLE[tlo][rhi];
    b_vhl <= AVAIL_TABLE[thi][rlo];
    b_vhh <= AVAIL_TABLE[thi][rhi];
    b_wr0 <= dr - fr;
    b_wr1 <= fr;
    b_wt0 <= dt - ft;
    b_wt1 <= ft;
    b_dt  <= dt;
    b_k   <= ksh;
  end

  // ---- corner weights ----
  logic               w_v;
  logic [CUR_W-1:0]   w_mag;
  logic               w_neg;
  logic [TBL_W-1:0]   w_vll, w_vlh, w_vhl, w_vhh;
  logic [WPROD_W-1:0] w_ll, w_lh, w_hl, w_hh;
  logic [TSPAN_W-1:0] w_dt;
  logic [KSH_W-1:0]   w_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_v <= 1'b0;
    end else begin
      w_v <= b_v;
    end
    w_mag <= b_mag;
    w_neg <= b_neg;
    w_vll <= b_vll;
    w_vlh <= b_vlh;
    w_vhl <= b_vhl;
    w_vhh <= b_vhh;
    w_ll  <= WPROD_W'(b_wr0) * WPROD_W'(b_wt0);
    w_lh  <= WPROD_W'(b_wr1) * WPROD_W'(b_wt0);
    w_hl  <= WPROD_W'(b_wr0) * WPROD_W'(b_wt1);
    w_hh  <= WPROD_W'(b_wr1) * WPROD_W'(b_wt1);
    w_dt  <= b_dt;
    w_k   <= b_k;
  end

  // ---- weighted corners ----
  logic               m_v;
  logic [CUR_W-1:0]   m_mag;
  logic               m_neg;
  logic [CPROD_W-1:0] m_ll, m_lh, m_hl, m_hh;
  logic [TSPAN_W-1:0] m_dt;
  logic [KSH_W-1:0]   m_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else begin
      m_v <= w_v;
    end
    m_mag <= w_mag;
    m_neg <= w_neg;
    m_ll  <= CPROD_W'(w_vll) * CPROD_W'(w_ll);
    m_lh  <= CPROD_W'(w_vlh) * CPROD_W'(w_lh);
    m_hl  <= CPROD_W'(w_vhl) * CPROD_W'(w_hl);
    m_hh  <= CPROD_W'(w_vhh) * CPROD_W'(w_hh);
    m_dt  <= w_dt;
    m_k   <= w_k;
  end

  // ---- sum, scale to Q16 and divide by temperature span ----
  logic [CSUM_W-1:0]           csum;
  logic [CSUM_W+RATE_FRAC-1:0] scaled;
  logic [SUM_W-1:0]            xsum;

  always_comb begin
    csum   = CSUM_W'(m_ll) + CSUM_W'(m_lh) + CSUM_W'(m_hl) + CSUM_W'(m_hh);
    scaled = {{RATE_FRAC{1'b0}}, csum} << m_k;
    xsum   = scaled[SUM_W-1:0];
  end

  logic               a_v   [AQ_BITS+1];
  logic [CUR_W-1:0]   a_mag [AQ_BITS+1];
  logic               a_neg [AQ_BITS+1];
  logic [AQ_BITS-1:0] a_q   [AQ_BITS+1];
  logic [AQ_BITS-1:0] a_x   [AQ_BITS];
  logic [TSPAN_W-1:0] a_dt  [AQ_BITS];
  logic [TSPAN_W-1:0] a_rem [AQ_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v[0] <= 1'b0;
    end else begin
      a_v[0] <= m_v;
    end
    a_mag[0] <= m_mag;
    a_neg[0] <= m_neg;
    a_q[0]   <= '0;
    a_x[0]   <= xsum[AQ_BITS-1:0];
    a_dt[0]  <= m_dt;
    a_rem[0] <= xsum[SUM_W-1:AQ_BITS];
  end

  for (genvar s = 1; s <= AQ_BITS; s++) begin : g_adiv
    logic [TSPAN_W:0] t;
    logic             ge;

    assign t  = {a_rem[s-1], a_x[s-1][AQ_BITS-s]};
    assign ge = t >= {1'b0, a_dt[s-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[s] <= 1'b0;
      end else begin
        a_v[s] <= a_v[s-1];
      end
      a_mag[s] <= a_mag[s-1];
      a_neg[s] <= a_neg[s-1];
      a_q[s]   <= {a_q[s-1][AQ_BITS-2:0], ge};
    end

    if (s < AQ_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        a_x[s]   <= a_x[s-1];
        a_dt[s]  <= a_dt[s-1];
        a_rem[s] <= ge ? TSPAN_W'(t - {1'b0, a_dt[s-1]}) : t[TSPAN_W-1:0];
      end
    end
  end

  assign out_valid      = a_v[AQ_BITS];
  assign out_word.neg   = a_neg[AQ_BITS];
  assign out_word.mag   = a_mag[AQ_BITS];
  assign out_word.avail = a_q[AQ_BITS];

`ifndef SYNTHESIS
  a_avail_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.avail >= PCT_LOW) && (out_word.avail <= PCT_HIGH))
    else $error("available percent outside table range");

  a_rate_top_collapses: assert property (@(posedge clk) disable iff (rst)
    r_v[RQ_BITS] && r_over[RQ_BITS] |=> (b_wr1 == '0) && (b_wr0 == RSPAN_W'(1)))
    else $error("saturated rate did not collapse its bracket");
`endif

endmodule

/* rtl/bcdd_queue.sv */
// Two-word queue between the front end and the charge back end.
// Register storage, head read from the current read pointer. Uses bcdd_pkg.
module bcdd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bcdd_pkg::bcdd_word_t push_word,
  input  logic                 pop,
  output bcdd_pkg::q_status_t  status,
  output bcdd_pkg::bcdd_word_t head
);
  import bcdd_pkg::*;

  bcdd_word_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign status.valid = count != '0;
  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign head         = mem[rd_ptr];
  assign do_pop       = pop && status.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push && status.full |-> pop)
    else $error("word pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

/* rtl/bcdd_back.sv */
// Back end: pops queued words and computes the saturated Q16.16 charge step.
// Pipelined restoring divider, one quotient bit per stage. Uses bcdd_pkg.
module bcdd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  bcdd_pkg::q_status_t               q_status,
  input  bcdd_pkg::bcdd_word_t              in_word,
  input  logic [bcdd_pkg::INT_W-1:0]        sample_interval_ms,
  output logic                              pop,
  output logic                              done,
  output logic signed [bcdd_pkg::DELTA_W-1:0] charge_delta,
  output logic [bcdd_pkg::PCT_W-1:0]        available_pct
);
  import bcdd_pkg::*;

  // never stalls: take the head whenever there is one
  assign pop = q_status.valid;

  logic              e_v;
  logic              e_neg;
  logic [PCT_W-1:0]  e_avail;
  logic [PROD_W-1:0] e_prod;
  logic [DEN_W-1:0]  e_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= pop;
    end
    e_neg   <= in_word.neg;
    e_avail <= in_word.avail;
    e_prod  <= PROD_W'(in_word.mag) * PROD_W'(sample_interval_ms);
    e_den   <= DEN_W'(in_word.avail) * DEN_W'(CHG_DEN);
  end

  logic               c_v     [CQ_BITS+1];
  logic               c_neg   [CQ_BITS+1];
  logic [PCT_W-1:0]   c_avail [CQ_BITS+1];
  logic               c_over  [CQ_BITS+1];
  logic [CQ_BITS-1:0] c_q     [CQ_BITS+1];
  logic [DEN_W-1:0]   c_rem   [CQ_BITS];
  logic [DEN_W-1:0]   c_den   [CQ_BITS];
  logic [CQ_BITS-1:0] c_low   [CQ_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else begin
      c_v[0] <= e_v;
    end
    c_neg[0]   <= e_neg;
    c_avail[0] <= e_avail;
    // quotient of 2^32 or more: saturates either way
    c_over[0]  <= DEN_W'(e_prod >> CDROP) >= e_den;
    c_q[0]     <= '0;
    c_rem[0]   <= DEN_W'(e_prod >> CDROP);
    c_den[0]   <= e_den;
    c_low[0]   <= CQ_BITS'({e_prod, {CHG_SHIFT{1'b0}}});
  end

  for (genvar s = 1; s <= CQ_BITS; s++) begin : g_cdiv
    logic [DEN_W:0] t;
    logic           ge;

    assign t  = {c_rem[s-1], c_low[s-1][CQ_BITS-s]};
    assign ge = t >= {1'b0, c_den[s-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[s] <= 1'b0;
      end else begin
        c_v[s] <= c_v[s-1];
      end
      c_neg[s]   <= c_neg[s-1];
      c_avail[s] <= c_avail[s-1];
      c_over[s]  <= c_over[s-1];
      c_q[s]     <= {c_q[s-1][CQ_BITS-2:0], ge};
    end

    if (s < CQ_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        c_den[s] <= c_den[s-1];
        c_low[s] <= c_low[s-1];
        c_rem[s] <= ge ? DEN_W'(t - {1'b0, c_den[s-1]}) : t[DEN_W-1:0];
      end
    end
  end

  logic [CQ_BITS-1:0] q;
  logic [DELTA_W-1:0] delta;

  always_comb begin
    q = c_q[CQ_BITS];
    if (c_avail[CQ_BITS] == '0) begin
      delta = '0;
    end else if (c_neg[CQ_BITS]) begin
      delta = (c_over[CQ_BITS] || q > DELTA_MIN_MAG) ? DELTA_MIN_MAG : (~q + 1'b1);
    end else begin
      delta = (c_over[CQ_BITS] || q > DELTA_MAX) ? DELTA_MAX : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_v[CQ_BITS];
    end
    charge_delta  <= delta;
    available_pct <= c_avail[CQ_BITS];
  end

`ifndef SYNTHESIS
  a_sign_follows_current: assert property (@(posedge clk) disable iff (rst)
    c_v[CQ_BITS] && !c_neg[CQ_BITS] |=> !charge_delta[DELTA_W-1])
    else $error("charge step negative for a charging word");
`endif

endmodule
